// ----- hdl/tts_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_pkg
// Shared types and constants of the tick task scheduler table.
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int TASK_SLOTS = 16;
  localparam int SLOT_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CNT_W      = $clog2(TASK_SLOTS + 1);
  localparam int RUN_SLOT_W = 4;

  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_DELETE   = 2'd1,
    OP_TICK     = 2'd2,
    OP_DISPATCH = 2'd3
  } op_e;

  localparam logic [1:0] ERR_NONE          = 2'd0;
  localparam logic [1:0] ERR_INVALID_INDEX = 2'd1;
  localparam logic [1:0] ERR_TOO_MANY      = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [31:0] delay;
    logic [31:0] period;
    logic [7:0]  pending;
    logic [7:0]  tag;
  } slot_t;

  typedef struct packed {
    op_e                   op;
    logic [31:0]           start_delay;
    logic [31:0]           repeat_period;
    logic                  run_once;
    logic [7:0]            task_tag;
    logic [RUN_SLOT_W-1:0] slot_index;
  } item_t;

  typedef struct packed {
    logic                  run_valid;
    logic [RUN_SLOT_W-1:0] run_slot;
    logic [7:0]            run_tag;
    logic [1:0]            error_status;
    logic                  last_result;
  } res_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    slot_t             data;
  } wr_req_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
  } rd_req_t;

endpackage

// ----- hdl/tts_slot_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_slot_ram
// Slot memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tts_slot_ram
  import tts_pkg::*;
(
  input  logic    clk_i,
  input  wr_req_t wr_i,
  input  rd_req_t rd_i,
  output slot_t   rd_data_o
);

  slot_t mem_q [TASK_SLOTS];
  slot_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rd_data_q <= mem_q[rd_i.addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- hdl/tts_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_engine
// Command sequencer: add and delete act on accept; tick and dispatch walk the
// slot memory one slot per cycle by read-modify-write unless a result stalls.
// ----------------------------------------------------------------------------
module tts_engine
  import tts_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_vld_i,
  output logic             in_stall_o,
  input  item_t            item_i,
  output logic             res_vld_o,
  input  logic             res_rdy_i,
  output res_t             res_o,
  output logic [CNT_W-1:0] used_o
);

  state_e                  state_q, state_d;
  op_e                     op_q, op_d;
  logic [SLOT_W-1:0]       idx_q, idx_d;
  logic [TASK_SLOTS-1:0]   valid_q, valid_d;
  logic [TASK_SLOTS-1:0]   once_q, once_d;
  logic [TASK_SLOTS-1:0]   nz_q, nz_d;
  logic [CNT_W-1:0]        used_q, used_d;
  logic [1:0]              err_q, err_d;

  wr_req_t                 wr;
  rd_req_t                 rd;
  slot_t                   rd_data;
  logic [TASK_SLOTS-1:0]   cand;
  logic [TASK_SLOTS-1:0]   hi_mask;
  logic                    step;
  logic                    at_end;
  logic [SLOT_W-1:0]       del_addr;

  tts_slot_ram u_ram (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_i      (rd),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_ADD;
      idx_q   <= '0;
      valid_q <= '0;
      once_q  <= '0;
      nz_q    <= '0;
      used_q  <= '0;
      err_q   <= ERR_NONE;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      idx_q   <= idx_d;
      valid_q <= valid_d;
      once_q  <= once_d;
      nz_q    <= nz_d;
      used_q  <= used_d;
      err_q   <= err_d;
    end
  end

  assign cand     = valid_q & nz_q;
  assign hi_mask  = {TASK_SLOTS{1'b1}} << (32'(idx_q) + 32'd1);
  assign at_end   = (32'(idx_q) + 32'd1) == 32'(used_q);
  assign del_addr = SLOT_W'(item_i.slot_index);

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    idx_d      = idx_q;
    valid_d    = valid_q;
    once_d     = once_q;
    nz_d       = nz_q;
    used_d     = used_q;
    err_d      = err_q;
    in_stall_o = 1'b1;
    rd.en      = 1'b0;
    rd.addr    = idx_q;
    wr.en      = 1'b0;
    wr.addr    = idx_q;
    wr.data    = rd_data;
    res_vld_o  = 1'b0;
    res_o      = '0;
    res_o.error_status = err_q;
    step       = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_vld_i) begin
          op_d = item_i.op;
          unique case (item_i.op)
            OP_ADD: begin
              wr.en           = 1'b1;
              wr.data.delay   = item_i.start_delay;
              wr.data.period  = item_i.repeat_period;
              wr.data.pending = '0;
              wr.data.tag     = item_i.task_tag;
              if (32'(used_q) < 32'(TASK_SLOTS)) begin
                wr.addr = SLOT_W'(used_q);
                used_d  = CNT_W'(used_q + 1'b1);
              end else begin
                wr.addr = SLOT_W'(TASK_SLOTS - 1);
                err_d   = ERR_TOO_MANY;
              end
              valid_d[wr.addr] = 1'b1;
              once_d[wr.addr]  = item_i.run_once;
              nz_d[wr.addr]    = 1'b0;
              state_d = ST_DONE;
            end
            OP_DELETE: begin
              if (32'(item_i.slot_index) >= 32'(used_q)) begin
                err_d = ERR_INVALID_INDEX;
              end else begin
                valid_d[del_addr] = 1'b0;
                once_d[del_addr]  = 1'b0;
                nz_d[del_addr]    = 1'b0;
              end
              state_d = ST_DONE;
            end
            OP_TICK, OP_DISPATCH: begin
              idx_d = '0;
              if (used_q == '0 || (item_i.op == OP_DISPATCH && cand == '0)) begin
                state_d = ST_DONE;
              end else begin
                rd.en   = 1'b1;
                rd.addr = '0;
                state_d = ST_WALK;
              end
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end

      ST_WALK: begin
        if (op_q == OP_TICK) begin
          if (valid_q[idx_q]) begin
            wr.en = 1'b1;
            if (rd_data.delay != '0) begin
              wr.data.delay = rd_data.delay - 32'd1;
            end else begin
              wr.data.delay = rd_data.period;
              if (rd_data.pending != 8'hFF) begin
                wr.data.pending = rd_data.pending + 8'd1;
              end
            end
            nz_d[idx_q] = (wr.data.pending != '0);
          end
        end else if (cand[idx_q]) begin
          res_vld_o         = 1'b1;
          res_o.run_valid   = 1'b1;
          res_o.run_slot    = RUN_SLOT_W'(idx_q);
          res_o.run_tag     = rd_data.tag;
          res_o.last_result = ((cand & hi_mask) == '0);
          if (res_rdy_i) begin
            wr.en           = 1'b1;
            wr.data.pending = rd_data.pending - 8'd1;
            nz_d[idx_q]     = (rd_data.pending != 8'd1);
            if (once_q[idx_q]) begin
              valid_d[idx_q] = 1'b0;
              once_d[idx_q]  = 1'b0;
            end
          end else begin
            step = 1'b0;
          end
        end
        if (step) begin
          if (at_end) begin
            state_d = (op_q == OP_TICK) ? ST_DONE : ST_IDLE;
          end else begin
            idx_d   = SLOT_W'(idx_q + 1'b1);
            rd.en   = 1'b1;
            rd.addr = SLOT_W'(idx_q + 1'b1);
          end
        end
      end

      ST_DONE: begin
        res_vld_o         = 1'b1;
        res_o.last_result = 1'b1;
        if (res_rdy_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign used_o = used_q;

endmodule

// ----- hdl/tick_task_scheduler_table_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tick_task_scheduler_table_top
// Task slot table with add, delete, tick and dispatch commands.
// ----------------------------------------------------------------------------
// input channel: one command word per transfer (in_vld_i / in_stall_o); the
// block takes one command at a time and raises in_stall_o until it is done.
// output channel: result words (out_vld_o / out_stall_i) from a single
// output register, so a finished word waits there without holding the core.
// add and delete: the table is updated on accept, then the single result word
// leaves ST_DONE through the output register.
// tick: the walk visits each used slot, then the result word leaves ST_DONE.
// dispatch: the walk visits each used slot, one result word per slot with
// pending runs in ascending slot order, last_result_o on the final word, or a
// single word from ST_DONE when nothing is pending; a stall on the output
// holds the walk on the current slot.
// the walk is paced by the single read port of the slot memory, which reads
// one slot per cycle unless stalled, writing back the previous slot alongside.
// reset: the table is empty, error status zero, no result pending; the slot
// memory needs no clearing pass.
// ----------------------------------------------------------------------------
module tick_task_scheduler_table_top
  import tts_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_vld_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [31:0] start_delay_i,
  input  logic [31:0] repeat_period_i,
  input  logic        run_once_i,
  input  logic [7:0]  task_tag_i,
  input  logic [3:0]  slot_index_i,
  output logic        out_vld_o,
  input  logic        out_stall_i,
  output logic        run_valid_o,
  output logic [3:0]  run_slot_o,
  output logic [7:0]  run_tag_o,
  output logic [1:0]  error_status_o,
  output logic        last_result_o
);

  item_t            item;
  res_t             res;
  res_t             res_q;
  logic             res_vld;
  logic             res_rdy;
  logic             out_vld_q;
  logic [CNT_W-1:0] used;

  assign item.op            = op_e'(op_i);
  assign item.start_delay   = start_delay_i;
  assign item.repeat_period = repeat_period_i;
  assign item.run_once      = run_once_i;
  assign item.task_tag      = task_tag_i;
  assign item.slot_index    = slot_index_i;

  tts_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_vld_i   (in_vld_i),
    .in_stall_o (in_stall_o),
    .item_i     (item),
    .res_vld_o  (res_vld),
    .res_rdy_i  (res_rdy),
    .res_o      (res),
    .used_o     (used)
  );

  assign res_rdy = !out_vld_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_rdy) begin
      out_vld_q <= res_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_rdy && res_vld) begin
      res_q <= res;
    end
  end

  assign out_vld_o      = out_vld_q;
  assign run_valid_o    = res_q.run_valid;
  assign run_slot_o     = res_q.run_slot;
  assign run_tag_o      = res_q.run_tag;
  assign error_status_o = res_q.error_status;
  assign last_result_o  = res_q.last_result;

  a_busy_after_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_vld_i && !in_stall_o |=> in_stall_o
  ) else $error("command accepted while previous one still running");

  a_idle_word_is_last: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_vld_o && !run_valid_o |-> last_result_o
  ) else $error("result without run request not marked final");

  a_used_in_range: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    32'(used) <= 32'(TASK_SLOTS)
  ) else $error("slot count beyond table size");

endmodule

// ----- sim/tick_task_scheduler_table_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tick_task_scheduler_table_top_tb
// Self-checking bench for the task slot table. A short table of commands
// covers the empty table, field extremes, bad delete indexes, deleted slots
// and one-shot tasks. Random commands follow: they fill the table until add
// overwrites the last slot. Every result word is checked against a model of
// the slot table kept in the bench. Both sides pause at random, and once the
// receiver holds off long enough for the block to stall its input.
// ----------------------------------------------------------------------------
module tick_task_scheduler_table_top_tb;
  import tts_pkg::*;

  localparam int          MAX_RUNS     = 17;
  localparam int          RANDOM_WORDS = 253;
  localparam int unsigned HOLD_START   = 1000;
  localparam int unsigned HOLD_LEN     = 400;
  localparam int unsigned QUIET_LO     = 1800;
  localparam int unsigned QUIET_HI     = 2800;
  localparam int unsigned RUN_LIMIT    = 400000;

  typedef struct packed {
    item_t cmd;
    logic  typed;
    res_t  want;
  } row_t;

  localparam res_t OK_WORD     = '{1'b0, 4'd0, 8'd0, ERR_NONE, 1'b1};
  localparam res_t BADIDX_WORD = '{1'b0, 4'd0, 8'd0, ERR_INVALID_INDEX, 1'b1};
  localparam res_t NO_WORD     = '0;

  localparam row_t DIRECTED_ROWS [17] = '{
    '{'{OP_TICK,     32'd0,          32'd0,          1'b0, 8'h00, 4'd0},  1'b1, OK_WORD},
    '{'{OP_DISPATCH, 32'd0,          32'd0,          1'b0, 8'h00, 4'd0},  1'b1, OK_WORD},
    '{'{OP_DELETE,   32'd0,          32'd0,          1'b0, 8'h00, 4'd0},  1'b1, BADIDX_WORD},
    '{'{OP_ADD,      32'd0,          32'd0,          1'b0, 8'hFF, 4'd0},  1'b1, BADIDX_WORD},
    '{'{OP_ADD,      32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, 8'h00, 4'd15}, 1'b1, BADIDX_WORD},
    '{'{OP_ADD,      32'd1,          32'd2,          1'b1, 8'hA5, 4'd0},  1'b1, BADIDX_WORD},
    '{'{OP_ADD,      32'd0,          32'd1,          1'b0, 8'h5A, 4'd0},  1'b1, BADIDX_WORD},
    '{'{OP_TICK,     32'd0,          32'd0,          1'b0, 8'h00, 4'd0},  1'b0, NO_WORD},
    '{'{OP_TICK,     32'd0,          32'd0,          1'b0, 8'h00, 4'd0},  1'b0, NO_WORD},
    '{'{OP_DISPATCH, 32'd0,          32'd0,          1'b0, 8'h00, 4'd0},  1'b0, NO_WORD},
    '{'{OP_DISPATCH, 32'd0,          32'd0,          1'b0, 8'h00, 4'd0},  1'b0, NO_WORD},
    '{'{OP_DELETE,   32'd0,          32'd0,          1'b0, 8'h00, 4'd3},  1'b1, BADIDX_WORD},
    '{'{OP_DELETE,   32'd0,          32'd0,          1'b0, 8'h00, 4'd4},  1'b1, BADIDX_WORD},
    '{'{OP_DELETE,   32'd0,          32'd0,          1'b0, 8'h00, 4'd15}, 1'b1, BADIDX_WORD},
    '{'{OP_TICK,     32'd0,          32'd0,          1'b0, 8'h00, 4'd0},  1'b0, NO_WORD},
    '{'{OP_DISPATCH, 32'd0,          32'd0,          1'b0, 8'h00, 4'd0},  1'b0, NO_WORD},
    '{'{OP_DISPATCH, 32'd0,          32'd0,          1'b0, 8'h00, 4'd0},  1'b0, NO_WORD}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        in_vld_i;
  logic        in_stall_o;
  logic [1:0]  op_i;
  logic [31:0] start_delay_i;
  logic [31:0] repeat_period_i;
  logic        run_once_i;
  logic [7:0]  task_tag_i;
  logic [3:0]  slot_index_i;
  logic        out_vld_o;
  logic        out_stall_i;
  logic        run_valid_o;
  logic [3:0]  run_slot_o;
  logic [7:0]  run_tag_o;
  logic [1:0]  error_status_o;
  logic        last_result_o;

  // bench copy of the slot table
  logic [31:0] slot_delay   [TASK_SLOTS];
  logic [31:0] slot_period  [TASK_SLOTS];
  logic [7:0]  slot_pending [TASK_SLOTS];
  logic        slot_once    [TASK_SLOTS];
  logic        slot_live    [TASK_SLOTS];
  logic [7:0]  slot_tag     [TASK_SLOTS];
  int          used_slots;
  logic [1:0]  table_err;

  res_t        due_words [$];
  int unsigned word_faults;
  int unsigned cycle_cnt;
  bit          tx_steady;

  tick_task_scheduler_table_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_vld_i        (in_vld_i),
    .in_stall_o      (in_stall_o),
    .op_i            (op_i),
    .start_delay_i   (start_delay_i),
    .repeat_period_i (repeat_period_i),
    .run_once_i      (run_once_i),
    .task_tag_i      (task_tag_i),
    .slot_index_i    (slot_index_i),
    .out_vld_o       (out_vld_o),
    .out_stall_i     (out_stall_i),
    .run_valid_o     (run_valid_o),
    .run_slot_o      (run_slot_o),
    .run_tag_o       (run_tag_o),
    .error_status_o  (error_status_o),
    .last_result_o   (last_result_o)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == RUN_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic void load_slot(input int idx, input item_t c);
    slot_delay[idx]   = c.start_delay;
    slot_period[idx]  = c.repeat_period;
    slot_pending[idx] = 8'd0;
    slot_once[idx]    = c.run_once;
    slot_tag[idx]     = c.task_tag;
    slot_live[idx]    = 1'b1;
  endfunction

  function automatic void drop_slot(input int idx);
    slot_delay[idx]   = 32'd0;
    slot_period[idx]  = 32'd0;
    slot_pending[idx] = 8'd0;
    slot_once[idx]    = 1'b0;
    slot_live[idx]    = 1'b0;
  endfunction

  // applies one command to the table copy and queues the words it yields
  function automatic void advance_table(input item_t c);
    int   runs;
    res_t w;
    runs = 0;
    case (c.op)
      OP_ADD: begin
        if (used_slots < TASK_SLOTS) begin
          load_slot(used_slots, c);
          used_slots++;
        end else begin
          table_err = ERR_TOO_MANY;
          load_slot(TASK_SLOTS - 1, c);
        end
      end
      OP_DELETE: begin
        if (int'(c.slot_index) >= used_slots) table_err = ERR_INVALID_INDEX;
        else drop_slot(int'(c.slot_index));
      end
      OP_TICK: begin
        for (int i = 0; i < used_slots; i++) begin
          if (slot_live[i]) begin
            if (slot_delay[i] != 32'd0) begin
              slot_delay[i] = slot_delay[i] - 32'd1;
            end else begin
              slot_delay[i] = slot_period[i];
              if (slot_pending[i] != 8'hFF) slot_pending[i] = slot_pending[i] + 8'd1;
            end
          end
        end
      end
      default: begin
        for (int i = 0; i < used_slots && runs < MAX_RUNS; i++) begin
          if (slot_live[i] && slot_pending[i] != 8'd0) begin
            slot_pending[i] = slot_pending[i] - 8'd1;
            w = '{1'b1, 4'(i), slot_tag[i], table_err, 1'b0};
            due_words.push_back(w);
            runs++;
            if (slot_once[i]) drop_slot(i);
          end
        end
      end
    endcase
    if (runs > 0) due_words[due_words.size() - 1].last_result = 1'b1;
    else due_words.push_back('{1'b0, 4'd0, 8'd0, table_err, 1'b1});
  endfunction

  function automatic item_t random_cmd();
    item_t c;
    int    pick;
    pick = $urandom_range(0, 99);
    c.op = (pick < 15) ? OP_ADD : (pick < 20) ? OP_DELETE :
           (pick < 62) ? OP_TICK : OP_DISPATCH;
    c.start_delay   = ($urandom_range(0, 15) == 0) ? $urandom() : $urandom_range(0, 3);
    c.repeat_period = ($urandom_range(0, 15) == 0) ? $urandom() : $urandom_range(0, 4);
    c.run_once      = ($urandom_range(0, 2) == 0);
    c.task_tag      = 8'($urandom_range(0, 255));
    c.slot_index    = 4'($urandom_range(0, 15));
    return c;
  endfunction

  task automatic send_word(input item_t c, input logic typed, input res_t want);
    int gap;
    gap = (!tx_steady && $urandom_range(0, 99) < 9) ? $urandom_range(1, 4) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_vld_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_vld_i        <= 1'b1;
    op_i            <= c.op;
    start_delay_i   <= c.start_delay;
    repeat_period_i <= c.repeat_period;
    run_once_i      <= c.run_once;
    task_tag_i      <= c.task_tag;
    slot_index_i    <= c.slot_index;
    do @(posedge clk_i); while (in_stall_o);
    advance_table(c);
    if (typed) begin
      void'(due_words.pop_back());
      due_words.push_back(want);
    end
  endtask

  task automatic check_word(input res_t got);
    res_t want;
    if (due_words.size() == 0) begin
      $error("unexpected result word %h", got);
      word_faults++;
    end else begin
      want = due_words.pop_front();
      if (got.run_valid != want.run_valid) begin
        $error("run_valid: expected %0d, actual %0d", want.run_valid, got.run_valid);
        word_faults++;
      end
      if (got.run_slot != want.run_slot) begin
        $error("run_slot: expected %0d, actual %0d", want.run_slot, got.run_slot);
        word_faults++;
      end
      if (got.run_tag != want.run_tag) begin
        $error("run_tag: expected %0d, actual %0d", want.run_tag, got.run_tag);
        word_faults++;
      end
      if (got.error_status != want.error_status) begin
        $error("error_status: expected %0d, actual %0d", want.error_status,
               got.error_status);
        word_faults++;
      end
      if (got.last_result != want.last_result) begin
        $error("last_result: expected %0d, actual %0d", want.last_result,
               got.last_result);
        word_faults++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_vld_o && !out_stall_i) begin
      check_word({run_valid_o, run_slot_o, run_tag_o, error_status_o, last_result_o});
    end
  end

  // receiver pacing, with one long hold-off
  initial begin : rx_pacing
    int unsigned hold_left;
    hold_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (cycle_cnt == HOLD_START) hold_left = HOLD_LEN;
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (cycle_cnt >= QUIET_LO && cycle_cnt < QUIET_HI) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < 9);
      end
    end
  end

  initial begin
    int    spin;
    cycle_cnt       = 0;
    word_faults     = 0;
    tx_steady       = 1'b0;
    rst_ni          = 1'b0;
    in_vld_i        = 1'b0;
    op_i            = OP_ADD;
    start_delay_i   = '0;
    repeat_period_i = '0;
    run_once_i      = 1'b0;
    task_tag_i      = '0;
    slot_index_i    = '0;
    used_slots      = 0;
    table_err       = ERR_NONE;
    for (int i = 0; i < TASK_SLOTS; i++) begin
      drop_slot(i);
      slot_tag[i] = 8'd0;
    end
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIRECTED_ROWS[r]) begin
      send_word(DIRECTED_ROWS[r].cmd, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
    end

    for (int k = 0; k < RANDOM_WORDS; k++) begin
      tx_steady = (k >= 40 && k < 90);
      send_word(random_cmd(), 1'b0, NO_WORD);
    end

    @(negedge clk_i);
    in_vld_i <= 1'b0;
    spin = 0;
    while (due_words.size() != 0 && spin < 6000) begin
      @(posedge clk_i);
      spin++;
    end
    repeat (40) @(posedge clk_i);
    if (due_words.size() != 0) begin
      $error("%0d expected result words never arrived", due_words.size());
      word_faults++;
    end
    if (word_faults == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/tts_pkg.sv
hdl/tts_slot_ram.sv
hdl/tts_engine.sv
hdl/tick_task_scheduler_table_top.sv
sim/tick_task_scheduler_table_top_tb.sv
